// ===== sv/sdcr_pkg.sv =====
// Shared types, constants and table functions for the stick shaping unit.
package sdcr_pkg;

  localparam logic [15:0] DZ_MAX       = 16'd62259;
  localparam logic [15:0] EXP_DEFAULT  = 16'd6554;
  localparam logic [15:0] EXP_MAX      = 16'd16384;
  localparam logic [14:0] RADIUS_RST   = 15'd156;
  localparam logic [15:0] EXP_RST      = 16'd6554;
  localparam logic [15:0] RAMP_RST     = 16'd512;
  localparam logic [63:0] Q30          = 64'd1 << 30;

  typedef enum logic [2:0] {
    REG_DEAD_ZONE   = 3'd0,
    REG_RADIUS      = 3'd1,
    REG_EXPONENT    = 3'd2,
    REG_STEER_RATE  = 3'd3,
    REG_THR_PRESS   = 3'd4,
    REG_THR_RELEASE = 3'd5,
    REG_BRK_PRESS   = 3'd6,
    REG_BRK_RELEASE = 3'd7
  } reg_idx_t;

  typedef enum logic [3:0] {
    MS_DZR   = 4'd0,
    MS_DEN   = 4'd1,
    MS_LGIDX = 4'd2,
    MS_LGINT = 4'd3,
    MS_NEG   = 4'd4,
    MS_EXIDX = 4'd5,
    MS_EXINT = 4'd6,
    MS_STEER = 4'd7,
    MS_THR   = 4'd8,
    MS_BRK   = 4'd9
  } mul_sel_t;

  typedef enum logic [1:0] {
    TG_ZERO  = 2'd0,
    TG_FULL  = 2'd1,
    TG_CURVE = 2'd2
  } tgt_sel_t;

  typedef struct packed {
    logic     load;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     div_init;
    logic     div_step;
    logic     norm_step;
    logic     rd_lo;
    logic     rd_hi;
    logic     rd_ex;
    logic     lg_sum;
    logic     tgt_en;
    tgt_sel_t tgt_sel;
    logic     commit;
  } dp_cmd_t;

  typedef struct packed {
    logic zero_tgt;
    logic full_tgt;
    logic div_last;
    logic t_zero;
    logic t_norm;
  } dp_stat_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] bit_m;
    v = v_in;
    r = 64'd0;
    bit_m = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (v >= r + bit_m) begin
        v = v - (r + bit_m);
        r = (r >> 1) + bit_m;
      end else begin
        r = r >> 1;
      end
      bit_m = bit_m >> 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] lg_frac(input logic [63:0] f);
    logic [63:0] x;
    logic [63:0] y;
    x = Q30 + f;
    y = 64'd0;
    for (int k = 1; k <= 30; k++) begin
      x = (x * x) >> 30;
      if (x >= 2 * Q30) begin
        x = x >> 1;
        y = y | (64'd1 << (30 - k));
      end
    end
    return y;
  endfunction

  function automatic logic [63:0] ex_frac(input logic [63:0] f);
    logic [63:0] roots [0:30];
    logic [63:0] r;
    roots[0] = 2 * Q30;
    for (int k = 1; k <= 30; k++) begin
      roots[k] = isqrt64(roots[k-1] << 30);
    end
    r = Q30;
    for (int k = 1; k <= 30; k++) begin
      if (f[30-k]) begin
        r = (r * roots[k]) >> 30;
      end
    end
    return r;
  endfunction

endpackage

// ===== sv/stick_deadzone_curve_and_ramps_unit.sv =====
// Stick dead zone, response curve, steering slew and pedal ramps: top level.
// Input channel: one frame per beat (raw stick sample, throttle/brake/handbrake
// flags, elapsed time); in_stall is high while a frame is in work.
// Output channel: one beat per frame with steering, throttle and brake levels
// (Q with LEVEL_FRAC_BITS fraction bits) and the handbrake flag.
// Configuration: cfg_valid/cfg_ready write port, cfg_index selects one of the
// eight registers; cfg_ready is always high. Write only while idle.
// A zero or full-scale target skips the curve; any other target goes through the
// bit-serial divider and the one-bit-per-cycle normalizer ahead of the table
// lookups. The next frame is taken in the cycle after a result is registered,
// while that result may still wait.
// A stalled output holds its beat; a finished frame waits until the output
// register frees before it updates the levels.
// Reset clears the levels, the output valid and the sequencer, and loads the
// register defaults.
module stick_deadzone_curve_and_ramps_unit
  import sdcr_pkg::*;
#(
  parameter int LEVEL_FRAC_BITS   = 16,
  parameter int CURVE_TABLE_DEPTH = 256
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [15:0]                in_raw_position,
  input  logic                              in_throttle_pressed,
  input  logic                              in_brake_pressed,
  input  logic                              in_handbrake_pressed,
  input  logic [15:0]                       in_elapsed_time,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [LEVEL_FRAC_BITS+1:0] out_steer_out,
  output logic [LEVEL_FRAC_BITS:0]          out_throttle_out,
  output logic [LEVEL_FRAC_BITS:0]          out_brake_out,
  output logic                              out_handbrake_out,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [2:0]                        cfg_index,
  input  logic [15:0]                       cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  sdcr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  sdcr_dp #(
    .LEVEL_FRAC_BITS   (LEVEL_FRAC_BITS),
    .CURVE_TABLE_DEPTH (CURVE_TABLE_DEPTH)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .stat                 (stat),
    .cfg_we               (cfg_valid & cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_raw_position      (in_raw_position),
    .in_throttle_pressed  (in_throttle_pressed),
    .in_brake_pressed     (in_brake_pressed),
    .in_handbrake_pressed (in_handbrake_pressed),
    .in_elapsed_time      (in_elapsed_time),
    .out_steer_out        (out_steer_out),
    .out_throttle_out     (out_throttle_out),
    .out_brake_out        (out_brake_out),
    .out_handbrake_out    (out_handbrake_out)
  );

endmodule

// ===== sv/sdcr_ctrl.sv =====
// Sequencer for the stick shaping unit: steps the datapath through one frame.
module sdcr_ctrl
  import sdcr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [20:0] {
    ST_IDLE   = 21'h000001,
    ST_DZR    = 21'h000002,
    ST_DEN    = 21'h000004,
    ST_CHK    = 21'h000008,
    ST_DIV    = 21'h000010,
    ST_NORM   = 21'h000020,
    ST_LGIDX  = 21'h000040,
    ST_LGLO   = 21'h000080,
    ST_LGHI   = 21'h000100,
    ST_LGINT  = 21'h000200,
    ST_LGSUM  = 21'h000400,
    ST_NEGMUL = 21'h000800,
    ST_EXIDX  = 21'h001000,
    ST_EXLO   = 21'h002000,
    ST_EXHI   = 21'h004000,
    ST_EXINT  = 21'h008000,
    ST_EXSUM  = 21'h010000,
    ST_STEPS  = 21'h020000,
    ST_STEPT  = 21'h040000,
    ST_STEPB  = 21'h080000,
    ST_UPD    = 21'h100000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    cmd.mul_sel = MS_DZR;
    cmd.tgt_sel = TG_ZERO;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = ST_DZR;
        end
      end
      ST_DZR: begin
        cmd.mul_en = 1'b1;
        cmd.mul_sel = MS_DZR;
        state_nxt = ST_DEN;
      end
      ST_DEN: begin
        cmd.mul_en = 1'b1;
        cmd.mul_sel = MS_DEN;
        state_nxt = ST_CHK;
      end
      ST_CHK: begin
        cmd.div_init = 1'b1;
        if (stat.zero_tgt) begin
          cmd.tgt_en = 1'b1;
          cmd.tgt_sel = TG_ZERO;
          state_nxt = ST_STEPS;
        end else if (stat.full_tgt) begin
          cmd.tgt_en = 1'b1;
          cmd.tgt_sel = TG_FULL;
          state_nxt = ST_STEPS;
        end else begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) state_nxt = ST_NORM;
      end
      ST_NORM: begin
        if (stat.t_zero) begin
          cmd.tgt_en = 1'b1;
          cmd.tgt_sel = TG_ZERO;
          state_nxt = ST_STEPS;
        end else if (stat.t_norm) begin
          state_nxt = ST_LGIDX;
        end else begin
          cmd.norm_step = 1'b1;
        end
      end
      ST_LGIDX: begin
        cmd.mul_en = 1'b1;
        cmd.mul_sel = MS_LGIDX;
        state_nxt = ST_LGLO;
      end
      ST_LGLO: begin
        cmd.rd_lo = 1'b1;
        state_nxt = ST_LGHI;
      end
      ST_LGHI: begin
        cmd.rd_hi = 1'b1;
        state_nxt = ST_LGINT;
      end
      ST_LGINT: begin
        cmd.mul_en = 1'b1;
        cmd.mul_sel = MS_LGINT;
        state_nxt = ST_LGSUM;
      end
      ST_LGSUM: begin
        cmd.lg_sum = 1'b1;
        state_nxt = ST_NEGMUL;
      end
      ST_NEGMUL: begin
        cmd.mul_en = 1'b1;
        cmd.mul_sel = MS_NEG;
        state_nxt = ST_EXIDX;
      end
      ST_EXIDX: begin
        cmd.mul_en = 1'b1;
        cmd.mul_sel = MS_EXIDX;
        state_nxt = ST_EXLO;
      end
      ST_EXLO: begin
        cmd.rd_lo = 1'b1;
        cmd.rd_ex = 1'b1;
        state_nxt = ST_EXHI;
      end
      ST_EXHI: begin
        cmd.rd_hi = 1'b1;
        cmd.rd_ex = 1'b1;
        state_nxt = ST_EXINT;
      end
      ST_EXINT: begin
        cmd.mul_en = 1'b1;
        cmd.mul_sel = MS_EXINT;
        state_nxt = ST_EXSUM;
      end
      ST_EXSUM: begin
        cmd.tgt_en = 1'b1;
        cmd.tgt_sel = TG_CURVE;
        state_nxt = ST_STEPS;
      end
      ST_STEPS: begin
        cmd.mul_en = 1'b1;
        cmd.mul_sel = MS_STEER;
        state_nxt = ST_STEPT;
      end
      ST_STEPT: begin
        cmd.mul_en = 1'b1;
        cmd.mul_sel = MS_THR;
        state_nxt = ST_STEPB;
      end
      ST_STEPB: begin
        cmd.mul_en = 1'b1;
        cmd.mul_sel = MS_BRK;
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = cmd.commit || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== sv/sdcr_dp.sv =====
// Datapath of the stick shaping unit: registers, shared multiplier, divider, tables.
module sdcr_dp
  import sdcr_pkg::*;
#(
  parameter int LEVEL_FRAC_BITS   = 16,
  parameter int CURVE_TABLE_DEPTH = 256
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  dp_cmd_t                           cmd,
  output dp_stat_t                          stat,
  input  logic                              cfg_we,
  input  logic [2:0]                        cfg_index,
  input  logic [15:0]                       cfg_data,
  input  logic signed [15:0]                in_raw_position,
  input  logic                              in_throttle_pressed,
  input  logic                              in_brake_pressed,
  input  logic                              in_handbrake_pressed,
  input  logic [15:0]                       in_elapsed_time,
  output logic signed [LEVEL_FRAC_BITS+1:0] out_steer_out,
  output logic [LEVEL_FRAC_BITS:0]          out_throttle_out,
  output logic [LEVEL_FRAC_BITS:0]          out_brake_out,
  output logic                              out_handbrake_out
);

  localparam int F   = LEVEL_FRAC_BITS;
  localparam int D   = CURVE_TABLE_DEPTH;
  localparam int IW  = $clog2(D + 1);
  localparam int LZW = $clog2(F + 1);
  localparam int STW = F + 8;
  localparam int MW  = F + 10;
  localparam logic [F:0] ONE = (F+1)'(1) << F;

  logic [15:0] dead_zone_r, exponent_r, steer_rate_r;
  logic [15:0] thr_press_r, thr_rel_r, brk_press_r, brk_rel_r;
  logic [14:0] radius_r;

  logic [15:0] mag_r;
  logic        neg_in_r, thr_held_r, brk_held_r, hb_r;
  logic [15:0] dt_r;

  logic [31:0] dzr_r;
  logic [30:0] den_r;
  logic [31:0] rem_r;
  logic [F-1:0] q_r;
  logic [LZW-1:0] div_cnt_r, lz_r;
  logic [IW-1:0] idx_r;
  logic [29:0] frac_r;
  logic [31:0] tlo_r, thi_r;
  logic [63:0] mul_r;
  logic [35:0] neg_r;
  logic [8:0]  ip_r;
  logic        fpnz_r;
  logic [F:0]  shaped_r;
  logic [STW-1:0] step_s_r, step_t_r, step_b_r;

  logic signed [F+1:0] steer_r;
  logic [F:0]          thr_r, brk_r;
  logic                hb_out_r;

  logic [15:0] dz_c, e_c;
  logic [35:0] ma;
  logic [31:0] mb;
  logic [67:0] mul_p;
  logic [31+F:0] step_wide;
  logic [STW-1:0] step_val;
  logic [31:0] shifted_mag, a_val;
  logic [32:0] rs;
  logic [29:0] u_lg, fp_ex, g_ex;
  logic [IW-1:0] rd_addr;
  logic [31:0] tab_val;
  logic [32:0] lg_val, ex_val, ex_shr;
  logic [9:0]  sh;
  logic [F:0]  curve_val;
  logic [31:0] lg_tab [0:D];
  logic [31:0] ex_tab [0:D];

  for (genvar gi = 0; gi < D; gi++) begin : g_tab
    localparam logic [63:0] FRAC = (64'(gi) << 30) / CURVE_TABLE_DEPTH;
    assign lg_tab[gi] = 32'(lg_frac(FRAC));
    assign ex_tab[gi] = 32'(ex_frac(FRAC));
  end
  assign lg_tab[D] = 32'(Q30);
  assign ex_tab[D] = 32'(2 * Q30);

  function automatic logic signed [MW-1:0] move_to(input logic signed [MW-1:0] cur,
                                                   input logic signed [MW-1:0] tgt,
                                                   input logic signed [MW-1:0] step);
    logic signed [MW-1:0] c;
    c = cur;
    if (tgt > cur) begin
      c = cur + step;
      if (c > tgt) c = tgt;
    end else if (tgt < cur) begin
      c = cur - step;
      if (c < tgt) c = tgt;
    end
    return c;
  endfunction

  assign dz_c = (dead_zone_r > DZ_MAX) ? DZ_MAX : dead_zone_r;
  assign e_c  = (exponent_r == 16'd0 || exponent_r > EXP_MAX) ? EXP_DEFAULT : exponent_r;

  assign u_lg  = {q_r[F-2:0], {(31-F){1'b0}}};
  assign fp_ex = mul_r[41:12];
  assign g_ex  = 30'(31'h40000000 - {1'b0, fp_ex});

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (cmd.mul_sel)
      MS_DZR: begin
        ma = 36'(dz_c);
        mb = 32'(radius_r);
      end
      MS_DEN: begin
        ma = 36'(radius_r);
        mb = 32'(17'h10000 - 17'(dz_c));
      end
      MS_LGIDX: begin
        ma = 36'(u_lg);
        mb = 32'(D);
      end
      MS_LGINT, MS_EXINT: begin
        ma = 36'(thi_r - tlo_r);
        mb = 32'(frac_r);
      end
      MS_NEG: begin
        ma = neg_r;
        mb = 32'(e_c);
      end
      MS_EXIDX: begin
        ma = 36'(g_ex);
        mb = 32'(D);
      end
      MS_STEER: begin
        ma = 36'(steer_rate_r);
        mb = 32'(dt_r);
      end
      MS_THR: begin
        ma = 36'(thr_held_r ? thr_press_r : thr_rel_r);
        mb = 32'(dt_r);
      end
      MS_BRK: begin
        ma = 36'(brk_held_r ? brk_press_r : brk_rel_r);
        mb = 32'(dt_r);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign mul_p     = 68'(ma) * 68'(mb);
  assign step_wide = {mul_p[31:0], {F{1'b0}}};
  assign step_val  = STW'(step_wide >> 24);

  assign shifted_mag = {mag_r, 16'd0};
  assign a_val       = shifted_mag - dzr_r;
  assign rs          = {rem_r, 1'b0};

  assign stat.zero_tgt = (radius_r == 15'd0) || (shifted_mag <= dzr_r);
  assign stat.full_tgt = (a_val >= {1'b0, den_r});
  assign stat.div_last = (div_cnt_r == LZW'(1));
  assign stat.t_zero   = (q_r == '0);
  assign stat.t_norm   = q_r[F-1];

  assign rd_addr = cmd.rd_hi ? idx_r + IW'(1) : idx_r;
  assign tab_val = cmd.rd_ex ? ex_tab[rd_addr] : lg_tab[rd_addr];

  assign lg_val = 33'(tlo_r) + 33'(mul_r >> 30);
  assign ex_val = 33'(tlo_r) + 33'(mul_r >> 30);
  assign sh     = 10'(30 - F) + 10'(ip_r) + 10'(fpnz_r);
  assign ex_shr = (sh >= 10'd33) ? 33'd0 : (ex_val >> sh);
  assign curve_val = (ex_shr > 33'(ONE)) ? ONE : (F+1)'(ex_shr);

  logic signed [MW-1:0] tgt_s, cur_s, new_s;
  logic signed [MW-1:0] thr_new, brk_new;
  logic                 returning;

  always_comb begin
    tgt_s = neg_in_r ? -$signed(MW'(shaped_r)) : $signed(MW'(shaped_r));
    cur_s = MW'(steer_r);
    returning = (cur_s > 0 && tgt_s >= 0 && tgt_s < cur_s) ||
                (cur_s < 0 && tgt_s <= 0 && tgt_s > cur_s);
    if (steer_rate_r == 16'd0 || dt_r == 16'd0) begin
      new_s = tgt_s;
    end else if (returning) begin
      new_s = move_to(cur_s, tgt_s, $signed(MW'(step_s_r)));
    end else begin
      new_s = tgt_s;
    end
    thr_new = move_to($signed(MW'(thr_r)), thr_held_r ? $signed(MW'(ONE)) : '0,
                      $signed(MW'(step_t_r)));
    brk_new = move_to($signed(MW'(brk_r)), brk_held_r ? $signed(MW'(ONE)) : '0,
                      $signed(MW'(step_b_r)));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dead_zone_r  <= 16'd0;
      radius_r     <= RADIUS_RST;
      exponent_r   <= EXP_RST;
      steer_rate_r <= 16'd0;
      thr_press_r  <= RAMP_RST;
      thr_rel_r    <= RAMP_RST;
      brk_press_r  <= RAMP_RST;
      brk_rel_r    <= RAMP_RST;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_DEAD_ZONE:   dead_zone_r  <= cfg_data;
        REG_RADIUS:      radius_r     <= cfg_data[14:0];
        REG_EXPONENT:    exponent_r   <= cfg_data;
        REG_STEER_RATE:  steer_rate_r <= cfg_data;
        REG_THR_PRESS:   thr_press_r  <= cfg_data;
        REG_THR_RELEASE: thr_rel_r    <= cfg_data;
        REG_BRK_PRESS:   brk_press_r  <= cfg_data;
        REG_BRK_RELEASE: brk_rel_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steer_r  <= '0;
      thr_r    <= '0;
      brk_r    <= '0;
      hb_out_r <= 1'b0;
    end else if (cmd.commit) begin
      steer_r  <= (F+2)'(new_s);
      thr_r    <= (F+1)'(thr_new);
      brk_r    <= (F+1)'(brk_new);
      hb_out_r <= hb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg_in_r   <= in_raw_position[15];
      mag_r      <= in_raw_position[15] ? 16'(17'h10000 - 17'({1'b0, in_raw_position}))
                                        : in_raw_position;
      thr_held_r <= in_throttle_pressed;
      brk_held_r <= in_brake_pressed;
      hb_r       <= in_handbrake_pressed;
      dt_r       <= in_elapsed_time;
    end
    if (cmd.mul_en) begin
      mul_r <= 64'(mul_p);
      unique case (cmd.mul_sel)
        MS_DZR: dzr_r <= 32'(mul_p);
        MS_DEN: den_r <= 31'(mul_p);
        MS_LGIDX: begin
          idx_r  <= IW'(mul_p >> 30);
          frac_r <= mul_p[29:0];
        end
        MS_EXIDX: begin
          idx_r  <= IW'(mul_p >> 30);
          frac_r <= mul_p[29:0];
          ip_r   <= 9'(mul_r >> 42);
          fpnz_r <= (fp_ex != 30'd0);
        end
        MS_STEER: step_s_r <= step_val;
        MS_THR:   step_t_r <= step_val;
        MS_BRK:   step_b_r <= step_val;
        default: ;
      endcase
    end
    if (cmd.div_init) begin
      rem_r     <= a_val;
      q_r       <= '0;
      div_cnt_r <= LZW'(F);
      lz_r      <= '0;
    end else if (cmd.div_step) begin
      div_cnt_r <= div_cnt_r - LZW'(1);
      if (rs >= {2'b00, den_r}) begin
        rem_r <= 32'(rs - {2'b00, den_r});
        q_r   <= {q_r[F-2:0], 1'b1};
      end else begin
        rem_r <= rs[31:0];
        q_r   <= {q_r[F-2:0], 1'b0};
      end
    end else if (cmd.norm_step) begin
      q_r  <= {q_r[F-2:0], 1'b0};
      lz_r <= lz_r + LZW'(1);
    end
    if (cmd.rd_lo) tlo_r <= tab_val;
    if (cmd.rd_hi) thi_r <= tab_val;
    if (cmd.lg_sum) neg_r <= ((36'(lz_r) + 36'd1) << 30) - 36'(lg_val);
    if (cmd.tgt_en) begin
      unique case (cmd.tgt_sel)
        TG_ZERO:  shaped_r <= '0;
        TG_FULL:  shaped_r <= ONE;
        TG_CURVE: shaped_r <= curve_val;
        default:  shaped_r <= '0;
      endcase
    end
  end

  assign out_steer_out     = steer_r;
  assign out_throttle_out  = thr_r;
  assign out_brake_out     = brk_r;
  assign out_handbrake_out = hb_out_r;

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the stick dead zone, curve and pedal ramp unit.
`timescale 1ns / 100ps

module testbench
  import sdcr_pkg::*;
();

  localparam int FRAC = 16;
  localparam int DEPTH = 256;
  localparam longint ONE = 64'd1 << FRAC;
  localparam longint unsigned QONE = 64'd1 << 30;
  localparam int STALL_LIMIT = 5000;

  typedef struct {
    logic [17:0] steer;
    logic [16:0] throttle;
    logic [16:0] brake;
    logic        handbrake;
  } level_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] in_raw_position = '0;
  logic in_throttle_pressed = 1'b0;
  logic in_brake_pressed = 1'b0;
  logic in_handbrake_pressed = 1'b0;
  logic [15:0] in_elapsed_time = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [17:0] out_steer_out;
  logic [16:0] out_throttle_out;
  logic [16:0] out_brake_out;
  logic out_handbrake_out;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  stick_deadzone_curve_and_ramps_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_raw_position(in_raw_position),
    .in_throttle_pressed(in_throttle_pressed),
    .in_brake_pressed(in_brake_pressed),
    .in_handbrake_pressed(in_handbrake_pressed),
    .in_elapsed_time(in_elapsed_time),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_steer_out(out_steer_out), .out_throttle_out(out_throttle_out),
    .out_brake_out(out_brake_out), .out_handbrake_out(out_handbrake_out),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  longint unsigned log_lut [0:DEPTH];
  longint unsigned pow_lut [0:DEPTH];
  longint unsigned half_roots [0:30];
  logic [15:0] shadow_regs [0:7];
  longint steer_lvl, throttle_lvl, brake_lvl;
  level_beat_t expected_levels [$];
  int mismatches = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  int stall_mode = 0;
  int stall_phase = 0;

  function automatic longint unsigned int_sqrt(input longint unsigned v_in);
    longint unsigned v, r, b;
    v = v_in;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint unsigned log2_fraction(input longint unsigned x_in);
    longint unsigned x, y;
    x = x_in;
    y = 0;
    for (int k = 1; k <= 30; k++) begin
      x = (x * x) >> 30;
      if (x >= 2 * QONE) begin
        x = x >> 1;
        y = y | (64'd1 << (30 - k));
      end
    end
    return y;
  endfunction

  function automatic longint unsigned exp2_fraction(input longint unsigned f);
    longint unsigned r;
    r = QONE;
    for (int k = 1; k <= 30; k++)
      if ((f >> (30 - k)) & 1) r = (r * half_roots[k]) >> 30;
    return r;
  endfunction

  function automatic longint unsigned lut_lookup(input bit use_pow,
                                                 input longint unsigned u);
    longint unsigned s, idx, rem, lo, hi;
    s = u * DEPTH;
    idx = s >> 30;
    rem = s & (QONE - 1);
    if (idx >= DEPTH) return use_pow ? pow_lut[DEPTH] : log_lut[DEPTH];
    lo = use_pow ? pow_lut[idx] : log_lut[idx];
    hi = use_pow ? pow_lut[idx + 1] : log_lut[idx + 1];
    return lo + (((hi - lo) * rem) >> 30);
  endfunction

  function automatic longint response_curve(input longint unsigned t,
                                            input longint unsigned e);
    int p;
    longint unsigned m, neg, prod, ip, fp, g, val, sh;
    p = FRAC - 1;
    while (p > 0 && ((t >> p) & 1) == 0) p--;
    m = t << (30 - p);
    neg = (longint'(FRAC - p) << 30) - lut_lookup(1'b0, m - QONE);
    prod = (neg * e) >> 12;
    ip = prod >> 30;
    fp = prod & (QONE - 1);
    g = (QONE - fp) & (QONE - 1);
    val = lut_lookup(1'b1, g);
    sh = (30 - FRAC) + ip + ((fp != 0) ? 1 : 0);
    if (sh >= 63) return 0;
    val = val >> sh;
    if (val > ONE) val = ONE;
    return longint'(val);
  endfunction

  function automatic longint stick_goal(input logic [15:0] raw);
    longint unsigned r, dz, e, mag, num, den, t;
    longint shaped;
    r = shadow_regs[REG_RADIUS];
    dz = shadow_regs[REG_DEAD_ZONE];
    e = shadow_regs[REG_EXPONENT];
    if (r == 0) return 0;
    if (dz > DZ_MAX) dz = DZ_MAX;
    if (e == 0 || e > EXP_MAX) e = EXP_DEFAULT;
    mag = raw[15] ? 65536 - raw : raw;
    if ((mag << 16) <= dz * r) return 0;
    num = ((mag << 16) - dz * r) << FRAC;
    den = r * (65536 - dz);
    t = num / den;
    if (t >= ONE) shaped = ONE;
    else if (t == 0) shaped = 0;
    else shaped = response_curve(t, e);
    return raw[15] ? -shaped : shaped;
  endfunction

  function automatic longint slew_step(input longint unsigned rate,
                                       input longint unsigned dt);
    return longint'(((rate * dt) << FRAC) >> 24);
  endfunction

  function automatic longint approach(input longint cur, input longint goal,
                                      input longint stp);
    longint c;
    c = cur;
    if (goal > c) begin
      c = c + stp;
      if (c > goal) c = goal;
    end else if (goal < c) begin
      c = c - stp;
      if (c < goal) c = goal;
    end
    return c;
  endfunction

  function automatic longint pedal_ramp(input longint cur, input bit held,
                                        input logic [15:0] up, input logic [15:0] down,
                                        input logic [15:0] dt);
    longint unsigned rate;
    rate = held ? up : down;
    if (rate == 0 || dt == 0) return cur;
    return approach(cur, held ? ONE : 0, slew_step(rate, dt));
  endfunction

  task automatic predict_levels(input logic [15:0] raw, input bit thr, input bit brk,
                                input bit hb, input logic [15:0] dt);
    longint goal;
    bit easing;
    level_beat_t beat;
    goal = stick_goal(raw);
    if (shadow_regs[REG_STEER_RATE] == 0 || dt == 0) begin
      steer_lvl = goal;
    end else begin
      easing = (steer_lvl > 0 && goal >= 0 && goal < steer_lvl) ||
               (steer_lvl < 0 && goal <= 0 && goal > steer_lvl);
      steer_lvl = easing ?
        approach(steer_lvl, goal, slew_step(shadow_regs[REG_STEER_RATE], dt)) : goal;
    end
    throttle_lvl = pedal_ramp(throttle_lvl, thr, shadow_regs[REG_THR_PRESS],
                              shadow_regs[REG_THR_RELEASE], dt);
    brake_lvl = pedal_ramp(brake_lvl, brk, shadow_regs[REG_BRK_PRESS],
                           shadow_regs[REG_BRK_RELEASE], dt);
    beat.steer = steer_lvl[17:0];
    beat.throttle = throttle_lvl[16:0];
    beat.brake = brake_lvl[16:0];
    beat.handbrake = hb;
    expected_levels.push_back(beat);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [15:0] value,
                           input bit hold_valid = 1'b0);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    if (!hold_valid) cfg_valid <= 1'b0;
    shadow_regs[idx] = (idx == REG_RADIUS) ? {1'b0, value[14:0]} : value;
  endtask

  task automatic send_frame(input logic [15:0] raw, input bit thr, input bit brk,
                            input bit hb, input logic [15:0] dt);
    in_valid <= 1'b1;
    in_raw_position <= raw;
    in_throttle_pressed <= thr;
    in_brake_pressed <= brk;
    in_handbrake_pressed <= hb;
    in_elapsed_time <= dt;
    do @(posedge clk); while (in_stall);
    predict_levels(raw, thr, brk, hb, dt);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 20);
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
    end
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (expected_levels.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic load_regs(input logic [15:0] dz, input logic [15:0] rad,
                           input logic [15:0] ex, input logic [15:0] sr,
                           input logic [15:0] tp, input logic [15:0] trl,
                           input logic [15:0] bp, input logic [15:0] brl);
    write_reg(REG_DEAD_ZONE, dz, 1'b1);
    write_reg(REG_RADIUS, rad, 1'b1);
    write_reg(REG_EXPONENT, ex, 1'b1);
    write_reg(REG_STEER_RATE, sr, 1'b1);
    write_reg(REG_THR_PRESS, tp, 1'b1);
    write_reg(REG_THR_RELEASE, trl, 1'b1);
    write_reg(REG_BRK_PRESS, bp, 1'b1);
    write_reg(REG_BRK_RELEASE, brl);
  endtask

  task automatic test_reset_defaults;
    send_frame(16'h8000, 1, 0, 1, 16'hFFFF);
    send_frame(16'h7FFF, 0, 1, 0, 16'hFFFF);
    send_frame(16'd0, 1, 1, 1, 16'd0);
    send_frame(16'd156, 0, 0, 0, 16'd100);
    send_frame(-16'sd156, 1, 0, 1, 16'd1);
    send_frame(16'd1, 1, 1, 0, 16'd2000);
    send_frame(-16'sd1, 0, 0, 1, 16'd2000);
    send_frame(16'd80, 1, 1, 0, 16'd0);
    drain();
  endtask

  task automatic test_dead_zone_and_curve;
    load_regs(16'hFFFF, 16'd32767, 16'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF);
    send_frame(16'h7FFF, 1, 1, 0, 16'd500);
    send_frame(16'd31000, 1, 0, 1, 16'd500);
    send_frame(-16'sd32000, 0, 1, 0, 16'd500);
    drain();
    load_regs(16'd0, 16'd0, 16'd16385, 16'd0, 16'd512, 16'd512, 16'd512, 16'd512);
    send_frame(16'd1000, 1, 0, 0, 16'd300);
    drain();
    load_regs(16'd6000, 16'd1000, 16'd16384, 16'd0, 16'd512, 16'd512, 16'd512, 16'd512);
    send_frame(16'd500, 1, 0, 0, 16'd300);
    send_frame(-16'sd900, 1, 0, 0, 16'd300);
    drain();
    write_reg(REG_EXPONENT, 16'd1);
    send_frame(16'd500, 0, 1, 1, 16'd300);
    drain();
  endtask

  task automatic test_steer_return;
    load_regs(16'd0, 16'd1000, 16'd4096, 16'd64, 16'd512, 16'd512, 16'd512, 16'd512);
    send_frame(16'd1000, 1, 1, 0, 16'd100);
    send_frame(16'd600, 1, 1, 0, 16'd100);
    send_frame(16'd0, 1, 1, 0, 16'd100);
    send_frame(16'd0, 0, 0, 0, 16'd0);
    send_frame(-16'sd1000, 0, 0, 1, 16'd100);
    send_frame(16'd800, 0, 0, 1, 16'd100);
    drain();
  endtask

  task automatic test_random_phase(input int frames);
    int lim;
    int mag;
    logic [15:0] raw;
    load_regs($urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 20000)),
              $urandom_range(0, 7) == 0 ? 16'($urandom) : 16'($urandom_range(0, 2000)),
              $urandom_range(0, 4) == 0 ? 16'($urandom) : 16'($urandom_range(1, 16384)),
              $urandom_range(0, 2) == 0 ? 16'd0 : 16'($urandom_range(1, 4000)),
              16'($urandom_range(0, 3000)), 16'($urandom_range(0, 3000)),
              $urandom_range(0, 5) == 0 ? 16'($urandom) : 16'($urandom_range(0, 3000)),
              $urandom_range(0, 5) == 0 ? 16'($urandom) : 16'($urandom_range(0, 3000)));
    lim = (shadow_regs[REG_RADIUS] * 5) / 4 + 2;
    if (lim > 32767) lim = 32767;
    for (int n = 0; n < frames; n++) begin
      case ($urandom_range(0, 3))
        0: raw = 16'($urandom);
        1: raw = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
        default: begin
          mag = $urandom_range(0, lim);
          raw = $urandom_range(0, 1) ? 16'(-mag) : 16'(mag);
        end
      endcase
      send_frame(raw, $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1),
                 $urandom_range(0, 7) == 0 ? 16'($urandom) :
                 ($urandom_range(0, 9) == 0 ? 16'd0 : 16'($urandom_range(1, 1500))));
    end
    drain();
  endtask

  always @(posedge clk) begin
    stall_phase <= stall_phase + 1;
    if (stall_phase % 97 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= $urandom_range(0, 1);
      2: out_stall <= $urandom_range(0, 9) < 8;
      default: out_stall <= (stall_phase % 5) < 2;
    endcase
  end

  always @(posedge clk) begin
    level_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_levels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat: steer %h", out_steer_out);
      end else begin
        want = expected_levels.pop_front();
        if (out_steer_out !== want.steer || out_throttle_out !== want.throttle ||
            out_brake_out !== want.brake || out_handbrake_out !== want.handbrake) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: steer %h/%h throttle %h/%h brake %h/%h hb %b/%b",
                     want.steer, out_steer_out, want.throttle, out_throttle_out,
                     want.brake, out_brake_out, want.handbrake, out_handbrake_out);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    half_roots[0] = 2 * QONE;
    for (int k = 1; k <= 30; k++) half_roots[k] = int_sqrt(half_roots[k - 1] << 30);
    for (int i = 0; i < DEPTH; i++) begin
      log_lut[i] = log2_fraction(QONE + ((longint'(i) << 30) / DEPTH));
      pow_lut[i] = exp2_fraction((longint'(i) << 30) / DEPTH);
    end
    log_lut[DEPTH] = QONE;
    pow_lut[DEPTH] = 2 * QONE;
    shadow_regs[REG_DEAD_ZONE] = 16'd0;
    shadow_regs[REG_RADIUS] = {1'b0, RADIUS_RST};
    shadow_regs[REG_EXPONENT] = EXP_RST;
    shadow_regs[REG_STEER_RATE] = 16'd0;
    shadow_regs[REG_THR_PRESS] = RAMP_RST;
    shadow_regs[REG_THR_RELEASE] = RAMP_RST;
    shadow_regs[REG_BRK_PRESS] = RAMP_RST;
    shadow_regs[REG_BRK_RELEASE] = RAMP_RST;
    steer_lvl = 0;
    throttle_lvl = 0;
    brake_lvl = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_dead_zone_and_curve();
    test_steer_return();
    for (int ph = 0; ph < 6; ph++) test_random_phase(315);
    if (mismatches == 0 && expected_levels.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/sdcr_pkg.sv
sv/sdcr_ctrl.sv
sv/sdcr_dp.sv
sv/stick_deadzone_curve_and_ramps_unit.sv
sim/testbench.sv
